>>> src/hrhp_pkg.sv
// types, codes and character constants shared by the request head parser
// no dependencies
`default_nettype none

package hrhp_pkg;

  localparam int unsigned RouteLenDefault = 64;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IndexW  = 6;

  typedef enum logic [2:0] {
    PH_METHOD   = 3'd0,
    PH_URL      = 3'd1,
    PH_PROTOCOL = 3'd2,
    PH_HNAME    = 3'd3,
    PH_HVALUE   = 3'd4,
    PH_SUCCESS  = 3'd5,
    PH_FAIL     = 3'd6
  } phase_e;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH    = 2'd0,
    REQ_ABORT   = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_PARSING = 2'd0,
    ST_SUCCESS = 2'd1,
    ST_FAIL    = 2'd2
  } status_e;

  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChQuery = 8'h3F;
  localparam logic [ByteW-1:0] ChColon = 8'h3A;

  // one result item as it leaves the step logic
  typedef struct packed {
    status_e           status;
    logic              route_valid;
    logic [ByteW-1:0]  route_byte;
    logic [IndexW-1:0] route_index;
    logic              route_overflow;
  } result_t;

endpackage

`default_nettype wire

>>> src/http_request_head_parser_top.sv
// top level of the request head parser: input register, step logic, result register
// depends on hrhp_pkg and hrhp_step
//
// usage
//   the slave stream carries one request item per handshake: tuser holds the
//   request type (push byte, abort, restart) and tdata holds the byte
//   the master stream returns exactly one result item per request item, in
//   order: parse status, and for url bytes before the first '?' the route
//   byte with its position, or an overflow flag once the route is full
// flow and throughput
//   an accepted item lands in the input register, then is run through the
//   parser state as it moves into the result register, which offers it on
//   the master side; a stall on the master side can hold it in the input
//   register in between
//   one item per cycle sustained while the receiver keeps tready high; the
//   only loop is the update of the parser state and route counter registers
// reset
//   rst_ni clears both stage valid flags and puts the parser in the method
//   phase with an empty route
// stall
//   when the receiver holds tready low the result register keeps its item,
//   the input register fills and then tready on the slave side drops; no
//   item is lost or repeated
`default_nettype none

module http_request_head_parser_top #(
  parameter int unsigned ROUTE_LEN = hrhp_pkg::RouteLenDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] byte_in
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  // master side
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [1:0] status, [2] route_valid, [10:3] route_byte, [16:11] route_index,
  // [17] route_overflow, [23:18] zero
  output logic [23:0]      m_axis_tdata_o
);

  // input stage
  logic                             in_valid_q;
  logic [hrhp_pkg::ReqW-1:0]        req_q;
  logic [hrhp_pkg::ByteW-1:0]       byte_q;

  // result stage
  logic                             out_valid_q;
  hrhp_pkg::result_t                result_q;
  hrhp_pkg::result_t                result_d;

  logic advance;  // input stage item moves into the result register

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      req_q  <= s_axis_tuser_i;
      byte_q <= s_axis_tdata_i;
    end
  end

  // parser state and per-item logic, stepped once for each item moved on
  hrhp_step #(
    .ROUTE_LEN(ROUTE_LEN)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .req_type_i (req_q),
    .byte_in_i  (byte_q),
    .result_o   (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0,
                            result_q.route_overflow,
                            result_q.route_index,
                            result_q.route_byte,
                            result_q.route_valid,
                            result_q.status};

endmodule

`default_nettype wire

>>> src/hrhp_step.sv
// parser state registers and the per-item next-state and result logic
// depends on hrhp_pkg
`default_nettype none

module hrhp_step #(
  parameter int unsigned ROUTE_LEN = hrhp_pkg::RouteLenDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic [hrhp_pkg::ReqW-1:0]  req_type_i,
  input  wire logic [hrhp_pkg::ByteW-1:0] byte_in_i,
  output hrhp_pkg::result_t               result_o
);

  localparam int unsigned CntW = $clog2(ROUTE_LEN + 1);
  localparam logic [CntW-1:0] RouteMax = CntW'(ROUTE_LEN);

  hrhp_pkg::phase_e phase_q, phase_d;
  logic             last_cr_q, last_cr_d;
  logic             in_query_q, in_query_d;
  logic             name_seen_q, name_seen_d;
  logic [CntW-1:0]  count_q, count_d;

  logic                    term;
  logic                    query_now;
  logic [CntW+hrhp_pkg::IndexW-1:0] count_ext;

  assign count_ext = {{hrhp_pkg::IndexW{1'b0}}, count_q};
  assign term      = (byte_in_i == hrhp_pkg::ChLf) && last_cr_q;
  assign query_now = in_query_q || (byte_in_i == hrhp_pkg::ChQuery);

  always_comb begin
    phase_d     = phase_q;
    last_cr_d   = last_cr_q;
    in_query_d  = in_query_q;
    name_seen_d = name_seen_q;
    count_d     = count_q;

    result_o.route_valid    = 1'b0;
    result_o.route_byte     = '0;
    result_o.route_index    = '0;
    result_o.route_overflow = 1'b0;

    unique case (hrhp_pkg::req_e'(req_type_i))
      hrhp_pkg::REQ_ABORT: begin
        phase_d = hrhp_pkg::PH_FAIL;
      end
      hrhp_pkg::REQ_RESTART: begin
        phase_d     = hrhp_pkg::PH_METHOD;
        last_cr_d   = 1'b0;
        in_query_d  = 1'b0;
        name_seen_d = 1'b0;
        count_d     = '0;
      end
      hrhp_pkg::REQ_PUSH: begin
        if (byte_in_i == hrhp_pkg::ChCr) begin
          last_cr_d = 1'b1;
        end else begin
          last_cr_d = 1'b0;
          case (phase_q)
            hrhp_pkg::PH_METHOD: begin
              if (term) phase_d = hrhp_pkg::PH_FAIL;
              else if (byte_in_i == hrhp_pkg::ChSpace) phase_d = hrhp_pkg::PH_URL;
            end
            hrhp_pkg::PH_URL: begin
              if (term) begin
                phase_d = hrhp_pkg::PH_FAIL;
              end else if (byte_in_i == hrhp_pkg::ChSpace) begin
                phase_d = hrhp_pkg::PH_PROTOCOL;
              end else begin
                in_query_d = query_now;
                if (!query_now) begin
                  if (count_q < RouteMax) begin
                    result_o.route_valid = 1'b1;
                    result_o.route_byte  = byte_in_i;
                    result_o.route_index = count_ext[hrhp_pkg::IndexW-1:0];
                    count_d              = count_q + 1'b1;
                  end else begin
                    result_o.route_overflow = 1'b1;
                  end
                end
              end
            end
            hrhp_pkg::PH_PROTOCOL: begin
              if (term) begin
                phase_d     = hrhp_pkg::PH_HNAME;
                name_seen_d = 1'b0;
              end
            end
            hrhp_pkg::PH_HNAME: begin
              if (term) begin
                phase_d = name_seen_q ? hrhp_pkg::PH_FAIL : hrhp_pkg::PH_SUCCESS;
              end else if (byte_in_i == hrhp_pkg::ChColon) begin
                phase_d = hrhp_pkg::PH_HVALUE;
              end else begin
                name_seen_d = 1'b1;
              end
            end
            hrhp_pkg::PH_HVALUE: begin
              if (term) begin
                phase_d     = hrhp_pkg::PH_HNAME;
                name_seen_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    case (phase_d)
      hrhp_pkg::PH_SUCCESS: result_o.status = hrhp_pkg::ST_SUCCESS;
      hrhp_pkg::PH_FAIL:    result_o.status = hrhp_pkg::ST_FAIL;
      default:              result_o.status = hrhp_pkg::ST_PARSING;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hrhp_pkg::PH_METHOD;
      last_cr_q   <= 1'b0;
      in_query_q  <= 1'b0;
      name_seen_q <= 1'b0;
      count_q     <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      last_cr_q   <= last_cr_d;
      in_query_q  <= in_query_d;
      name_seen_q <= name_seen_d;
      count_q     <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_http_request_head_parser_top.sv
// self-checking testbench for http_request_head_parser_top: directed table, then random requests
// depends on hrhp_pkg and the rtl under src, result items checked against a local parse predictor
module tb_http_request_head_parser_top;
  import hrhp_pkg::*;

  localparam int unsigned RouteCap      = RouteLenDefault;
  localparam int          RandomItems   = 450;
  // slowest legal quiet stretch: receiver stall window plus sender gap plus
  // two pipeline stages, taken many times over
  localparam int          WatchdogLimit = 1000;
  localparam int          TailCycles    = 8;

  // directed stimulus row, result typed in only where it is obvious
  typedef struct {
    req_e             r;
    logic [ByteW-1:0] b;
    bit               typed;
    result_t          res;
  } dir_row_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = 8'h00;
  logic [1:0]  s_user  = REQ_NONE;
  logic        m_ready = 1'b0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [23:0] m_axis_tdata_o;

  // parse predictor state
  phase_e      ph;
  bit          cr_seen;
  bit          query_seen;
  bit          name_seen;
  int unsigned route_cnt;

  result_t     pending_results[$];
  dir_row_t    dir_tab[$];
  int          mismatches  = 0;
  int          counted     = 0;
  int          burst_left  = 0;
  int          idle_cycles = 0;
  int unsigned rx_cycle    = 0;

  always #2 clk_i = ~clk_i;

  http_request_head_parser_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),   // [7:0] byte_in
    .s_axis_tuser_i  (s_user),   // [1:0] req_type
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    // [1:0] status, [2] route_valid, [10:3] route_byte, [16:11] route_index,
    // [17] route_overflow
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // ---------------------------------------------------------------- predictor

  function automatic void parse_reset();
    ph         = PH_METHOD;
    cr_seen    = 1'b0;
    query_seen = 1'b0;
    name_seen  = 1'b0;
    route_cnt  = 0;
  endfunction

  // advance the predicted parser by one request item, return its result
  function automatic result_t parse_step(input req_e r, input logic [ByteW-1:0] b);
    result_t res;
    logic    line_end;
    res      = '0;
    line_end = 1'b0;
    case (r)
      REQ_ABORT: ph = PH_FAIL;
      REQ_RESTART: parse_reset();
      REQ_PUSH: begin
        if (b == ChCr) begin
          // cr is only remembered, it never reaches a phase
          cr_seen = 1'b1;
        end else begin
          // only cr followed by lf ends a line, a lone lf is ordinary text
          line_end = (b == ChLf) && cr_seen;
          case (ph)
            PH_METHOD: begin
              if (line_end) ph = PH_FAIL;
              else if (b == ChSpace) ph = PH_URL;
            end
            PH_URL: begin
              if (line_end) begin
                ph = PH_FAIL;
              end else if (b == ChSpace) begin
                ph = PH_PROTOCOL;
              end else begin
                if (b == ChQuery) query_seen = 1'b1;
                if (!query_seen) begin
                  if (route_cnt < RouteCap) begin
                    res.route_valid = 1'b1;
                    res.route_byte  = b;
                    res.route_index = route_cnt[IndexW-1:0];
                    route_cnt++;
                  end else begin
                    // route full, byte dropped
                    res.route_overflow = 1'b1;
                  end
                end
              end
            end
            PH_PROTOCOL: begin
              if (line_end) begin
                ph        = PH_HNAME;
                name_seen = 1'b0;
              end
            end
            PH_HNAME: begin
              // empty header line closes the head, a name without colon fails
              if (line_end) ph = name_seen ? PH_FAIL : PH_SUCCESS;
              else if (b == ChColon) ph = PH_HVALUE;
              else name_seen = 1'b1;
            end
            PH_HVALUE: begin
              if (line_end) begin
                ph        = PH_HNAME;
                name_seen = 1'b0;
              end
            end
            default: ;  // success and failure ignore bytes
          endcase
          cr_seen = 1'b0;
        end
      end
      default: ;  // unused request type changes nothing
    endcase
    res.status = (ph == PH_SUCCESS) ? ST_SUCCESS : (ph == PH_FAIL) ? ST_FAIL : ST_PARSING;
    return res;
  endfunction

  // ------------------------------------------------------------------ sender

  // offer one item, bursts of random length with random gaps in between;
  // at acceptance the predictor runs and the expected result is queued
  task automatic send_item(input req_e r, input logic [ByteW-1:0] b,
                           input bit typed, input result_t want);
    result_t pred;
    int      gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_user  <= r;
    s_data  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    counted++;
    pred = parse_step(r, b);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic push(input logic [ByteW-1:0] b);
    send_item(REQ_PUSH, b, 1'b0, '0);
  endtask

  task automatic send_req(input req_e r);
    send_item(r, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // hold off the sender until every queued result has come back
  task automatic wait_for_results();
    s_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // random text byte, never cr; plain text also avoids space, '?' and ':'
  function automatic logic [ByteW-1:0] text_byte(input bit plain);
    logic [ByteW-1:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == ChCr ||
               (plain && (b == ChSpace || b == ChQuery || b == ChColon)));
    return b;
  endfunction

  function automatic logic [ByteW-1:0] marker_byte();
    case ($urandom_range(0, 4))
      0: return ChCr;
      1: return ChLf;
      2: return ChSpace;
      3: return ChQuery;
      default: return ChColon;
    endcase
  endfunction

  // one request head with random content, mostly well formed;
  // flaw 6 ends the method line, 7 ends the url line, 8 leaves a header
  // line without colon, 9 aborts before the closing empty line
  task automatic send_request();
    int flaw;
    int url_len;
    flaw = $urandom_range(0, 9);
    repeat ($urandom_range(1, 6)) push(text_byte(1'b1));
    if (flaw == 6) begin
      push(ChCr);
      push(ChLf);
    end
    push(ChSpace);
    // now and then a url long enough to fill or nearly fill the route
    url_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 12);
    for (int i = 0; i < url_len; i++) begin
      push(($urandom_range(0, 15) == 0) ? ChQuery : text_byte(1'b1));
    end
    if (flaw == 7) begin
      push(ChCr);
      push(ChLf);
    end else begin
      push(ChSpace);
      repeat ($urandom_range(1, 8)) push(text_byte(1'b0));
      push(ChCr);
      push(ChLf);
      repeat ($urandom_range(0, 3)) begin
        repeat ($urandom_range(0, 6)) push(text_byte(1'b1));
        push(ChColon);
        repeat ($urandom_range(0, 8)) push(text_byte(1'b0));
        push(ChCr);
        push(ChLf);
      end
      if (flaw == 8) repeat ($urandom_range(1, 4)) push(text_byte(1'b1));
      if (flaw == 9) send_req(REQ_ABORT);
      push(ChCr);
      push(ChLf);
    end
    // stray bytes past the end of the head
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push(text_byte(1'b0));
    send_req(REQ_RESTART);
  endtask

  // any request type, bytes biased toward line and field markers
  task automatic send_noise();
    req_e             r;
    logic [ByteW-1:0] b;
    repeat ($urandom_range(4, 24)) begin
      r = ($urandom_range(0, 7) < 6) ? REQ_PUSH : req_e'($urandom_range(1, 3));
      b = ($urandom_range(0, 2) == 0) ? marker_byte() : 8'($urandom_range(0, 255));
      send_item(r, b, 1'b0, '0);
    end
    send_req(REQ_RESTART);
  endtask

  function automatic dir_row_t mk(input req_e r, input logic [ByteW-1:0] b,
                                  input bit typed = 1'b0,
                                  input status_e st = ST_PARSING,
                                  input logic rv = 1'b0,
                                  input logic [ByteW-1:0] rb = '0,
                                  input logic [IndexW-1:0] ri = '0,
                                  input logic ro = 1'b0);
    dir_row_t row;
    row.r                  = r;
    row.b                  = b;
    row.typed              = typed;
    row.res.status         = st;
    row.res.route_valid    = rv;
    row.res.route_byte     = rb;
    row.res.route_index    = ri;
    row.res.route_overflow = ro;
    return row;
  endfunction

  // ---------------------------------------------------------------- receiver

  // stall pattern cycles through always ready, one in four, random and long stalls
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[8:7])
      2'd0:    m_ready <= 1'b1;
      2'd1:    m_ready <= (rx_cycle[1:0] != 2'd3);
      2'd2:    m_ready <= ($urandom_range(0, 3) != 0);
      default: m_ready <= (rx_cycle[3:0] < 4'd6);
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // compare each accepted result item with the oldest expected one
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_results.size() == 0) begin
        $error("result item %0h with none expected", m_axis_tdata_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status",         32'(want.status),         32'(m_axis_tdata_o[1:0]));
        check_field("route_valid",    32'(want.route_valid),    32'(m_axis_tdata_o[2]));
        check_field("route_byte",     32'(want.route_byte),     32'(m_axis_tdata_o[10:3]));
        check_field("route_index",    32'(want.route_index),    32'(m_axis_tdata_o[16:11]));
        check_field("route_overflow", 32'(want.route_overflow), 32'(m_axis_tdata_o[17]));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    parse_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // a well formed head with route extremes, then the end cases
    dir_tab.push_back(mk(REQ_PUSH, "G", 1'b1, ST_PARSING));
    dir_tab.push_back(mk(REQ_PUSH, ChSpace, 1'b1, ST_PARSING));
    dir_tab.push_back(mk(REQ_PUSH, "/", 1'b1, ST_PARSING, 1'b1, "/", 6'd0));
    dir_tab.push_back(mk(REQ_PUSH, 8'hFF, 1'b1, ST_PARSING, 1'b1, 8'hFF, 6'd1));
    dir_tab.push_back(mk(REQ_PUSH, 8'h00, 1'b1, ST_PARSING, 1'b1, 8'h00, 6'd2));
    // lone lf inside the url is a route byte
    dir_tab.push_back(mk(REQ_PUSH, ChLf, 1'b1, ST_PARSING, 1'b1, ChLf, 6'd3));
    dir_tab.push_back(mk(REQ_PUSH, ChQuery, 1'b1, ST_PARSING));
    dir_tab.push_back(mk(REQ_PUSH, "q"));
    dir_tab.push_back(mk(REQ_PUSH, ChSpace));
    dir_tab.push_back(mk(REQ_PUSH, "H"));
    dir_tab.push_back(mk(REQ_PUSH, ChCr));
    dir_tab.push_back(mk(REQ_PUSH, ChLf));
    dir_tab.push_back(mk(REQ_PUSH, "A"));
    dir_tab.push_back(mk(REQ_PUSH, ChColon));
    dir_tab.push_back(mk(REQ_PUSH, ChCr));
    dir_tab.push_back(mk(REQ_PUSH, ChLf));
    dir_tab.push_back(mk(REQ_PUSH, ChCr));
    dir_tab.push_back(mk(REQ_PUSH, ChLf, 1'b1, ST_SUCCESS));
    // bytes after the end and the unused request type leave status alone
    dir_tab.push_back(mk(REQ_PUSH, "Z", 1'b1, ST_SUCCESS));
    dir_tab.push_back(mk(REQ_NONE, 8'hFF, 1'b1, ST_SUCCESS));
    dir_tab.push_back(mk(REQ_RESTART, 8'h00, 1'b1, ST_PARSING));
    // line end inside the method
    dir_tab.push_back(mk(REQ_PUSH, ChCr));
    dir_tab.push_back(mk(REQ_PUSH, ChLf, 1'b1, ST_FAIL));
    dir_tab.push_back(mk(REQ_RESTART, 8'hA5, 1'b1, ST_PARSING));
    dir_tab.push_back(mk(REQ_ABORT, 8'h5A, 1'b1, ST_FAIL));
    dir_tab.push_back(mk(REQ_RESTART, 8'h00, 1'b1, ST_PARSING));

    foreach (dir_tab[i]) send_item(dir_tab[i].r, dir_tab[i].b, dir_tab[i].typed, dir_tab[i].res);
    wait_for_results();

    while (counted < RandomItems) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_request();
      if ($urandom_range(0, 15) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> http_request_head_parser_top.f
src/hrhp_pkg.sv
src/hrhp_step.sv
src/http_request_head_parser_top.sv
verif/tb_http_request_head_parser_top.sv
